// ===== src/levenshtein_edit_distance_top_assert.svh =====
// Assertion macros for the edit distance engine checker.
// Taken in by the checker file only; no other dependencies.
`ifndef LEVENSHTEIN_EDIT_DISTANCE_TOP_ASSERT_SVH
`define LEVENSHTEIN_EDIT_DISTANCE_TOP_ASSERT_SVH

// Same-edge implication, sampled on clk_i, off while rst_ni is low.
`define LEV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("edit distance check failed");

// Next-edge implication, sampled on clk_i, off while rst_ni is low.
`define LEV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("edit distance check failed");

`endif

// ===== src/lev_pkg.sv =====
// Shared types and constants for the edit distance engine.
// No dependencies; used by the top level and its checker.
package lev_pkg;

  localparam int MaxLenDefault = 64;
  localparam int CharW         = 16;
  localparam int DistW         = 7;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_TARGET = 2'd1,
    OP_SOURCE = 2'd2,
    OP_FINISH = 2'd3
  } lev_op_e;

  typedef struct packed {
    lev_op_e            opcode;
    logic [CharW-1:0]   char_code;
  } lev_req_t;

  typedef struct packed {
    logic [DistW-1:0]   distance;
    logic               length_error;
  } lev_rsp_t;

endpackage

// ===== src/levenshtein_edit_distance_top.sv =====
// Edit distance engine: target string store, cost column memory, column walker.
// Depends on lev_pkg.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid_i / req_stall_o  lev_req_t (opcode, char_code)
//   rsp      out        rsp_valid_o / rsp_stall_i  lev_rsp_t (distance, length_error)
//
// Start, target and rejected items are handled in the idle state; a source char
// walks the column, one column entry per cycle through the single read port
// of the cost column memory. Finish reads the last column entry, then waits
// for the output register. Reset clears lengths, the error flag and the FSM;
// memories are not cleared. A held result does not block non-finish requests.
module levenshtein_edit_distance_top import lev_pkg::*; #(
  parameter int MAX_LEN = MaxLenDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_stall_o,
  input  lev_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_stall_i,
  output lev_rsp_t rsp_o
);

  localparam int LenW  = $clog2(MAX_LEN + 1);
  localparam int TAddrW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [LenW-1:0] MaxLenL = LenW'(MAX_LEN);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } lev_state_e;

  lev_state_e state_q, state_d;
  logic [LenW-1:0] tlen_q, tlen_d, slen_q, slen_d;
  logic            err_q, err_d;
  logic            rsp_valid_q, rsp_valid_d;
  lev_rsp_t        rsp_q, rsp_d;

  logic [CharW-1:0] ch_q, ch_d;
  logic [LenW-1:0]  diag_q, diag_d, left_q, left_d, j_q, j_d;

  // Memories
  logic [CharW-1:0] tgt_mem [MAX_LEN];
  logic [LenW-1:0]  col_mem [MAX_LEN+1];
  logic             tgt_we, tgt_re, col_we, col_re;
  logic [TAddrW-1:0] tgt_waddr, tgt_raddr;
  logic [CharW-1:0] tgt_wdata, tgt_rd_q;
  logic [LenW-1:0]  col_waddr, col_raddr, col_wdata, col_rd_q;

  always_ff @(posedge clk_i) begin
    if (tgt_we) begin
      tgt_mem[tgt_waddr] <= tgt_wdata;
    end
    if (tgt_re) begin
      tgt_rd_q <= tgt_mem[tgt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    if (col_re) begin
      col_rd_q <= col_mem[col_raddr];
    end
  end

  // Shared cell unit: min of left + 1, up + 1, diag + mismatch
  logic [LenW:0]   left_inc, up_inc, sub_cost, min_lu, cell_min;
  logic [LenW-1:0] cell_val;
  always_comb begin
    left_inc = {1'b0, left_q} + 1'b1;
    up_inc   = {1'b0, col_rd_q} + 1'b1;
    sub_cost = {1'b0, diag_q} + {{LenW{1'b0}}, (tgt_rd_q != ch_q)};
    min_lu   = (left_inc < up_inc) ? left_inc : up_inc;
    cell_min = (min_lu < sub_cost) ? min_lu : sub_cost;
    cell_val = cell_min[LenW-1:0];
  end

  logic [LenW-1:0]       fin_dist;
  logic [LenW+DistW-1:0] fin_ext;
  always_comb begin
    fin_dist = (tlen_q == '0) ? slen_q : col_rd_q;
    fin_ext  = {{DistW{1'b0}}, fin_dist};
  end

  always_comb begin
    state_d     = state_q;
    tlen_d      = tlen_q;
    slen_d      = slen_q;
    err_d       = err_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    ch_d        = ch_q;
    diag_d      = diag_q;
    left_d      = left_q;
    j_d         = j_q;
    tgt_we      = 1'b0;
    tgt_waddr   = tlen_q[TAddrW-1:0];
    tgt_wdata   = req_i.char_code;
    tgt_re      = 1'b0;
    tgt_raddr   = '0;
    col_we      = 1'b0;
    col_waddr   = '0;
    col_wdata   = '0;
    col_re      = 1'b0;
    col_raddr   = '0;

    if (rsp_valid_q && !rsp_stall_i) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          case (req_i.opcode)
            OP_START: begin
              tlen_d = '0;
              slen_d = '0;
              err_d  = 1'b0;
            end
            OP_TARGET: begin
              if (slen_q != '0 || tlen_q >= MaxLenL) begin
                err_d = 1'b1;
              end else begin
                tgt_we    = 1'b1;
                col_we    = 1'b1;
                col_waddr = tlen_q + 1'b1;
                col_wdata = tlen_q + 1'b1;
                tlen_d    = tlen_q + 1'b1;
              end
            end
            OP_SOURCE: begin
              if (slen_q >= MaxLenL) begin
                err_d = 1'b1;
              end else if (tlen_q == '0) begin
                slen_d = slen_q + 1'b1;
              end else begin
                // prime the walk with the first column entry
                ch_d      = req_i.char_code;
                diag_d    = slen_q;
                left_d    = slen_q + 1'b1;
                j_d       = '0;
                col_re    = 1'b1;
                col_raddr = LenW'(1);
                tgt_re    = 1'b1;
                tgt_raddr = '0;
                state_d   = ST_WALK;
              end
            end
            OP_FINISH: begin
              col_re    = 1'b1;
              col_raddr = tlen_q;
              state_d   = ST_FIN;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        col_we    = 1'b1;
        col_waddr = j_q + 1'b1;
        col_wdata = cell_val;
        diag_d    = col_rd_q;
        left_d    = cell_val;
        if ((j_q + 1'b1) < tlen_q) begin
          // advance: read the next entry while this one is written back
          j_d       = j_q + 1'b1;
          col_re    = 1'b1;
          col_raddr = j_q + LenW'(2);
          tgt_re    = 1'b1;
          tgt_raddr = TAddrW'(j_q + 1'b1);
        end else begin
          slen_d  = slen_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!rsp_valid_q || !rsp_stall_i) begin
          rsp_valid_d          = 1'b1;
          rsp_d.distance       = fin_ext[DistW-1:0];
          rsp_d.length_error   = err_q;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tlen_q      <= '0;
      slen_q      <= '0;
      err_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tlen_q      <= tlen_d;
      slen_q      <= slen_d;
      err_q       <= err_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q  <= rsp_d;
    ch_q   <= ch_d;
    diag_q <= diag_d;
    left_q <= left_d;
    j_q    <= j_d;
  end

  assign req_stall_o = (state_q != ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== src/lev_checker.sv =====
// Port-level checker for the edit distance engine, bound to the top level.
// Depends on lev_pkg and levenshtein_edit_distance_top_assert.svh.
`include "levenshtein_edit_distance_top_assert.svh"

module lev_checker import lev_pkg::*; #(
  parameter int MAX_LEN = MaxLenDefault
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     req_valid_i,
  input logic     req_stall_o,
  input lev_req_t req_i,
  input logic     rsp_valid_o,
  input logic     rsp_stall_i,
  input lev_rsp_t rsp_o
);

  logic req_take;
  assign req_take = req_valid_i && !req_stall_o;

  // a stalled result stays put
  `LEV_ASSERT_NEXT(a_rsp_hold, rsp_valid_o && rsp_stall_i, rsp_valid_o && $stable(rsp_o))

  // a finish request always occupies the engine for the next cycle
  `LEV_ASSERT_NEXT(a_finish_busy, req_take && req_i.opcode == OP_FINISH, req_stall_o)

  // a start request completes in its own cycle
  `LEV_ASSERT_NEXT(a_start_quick, req_take && req_i.opcode == OP_START, !req_stall_o)

  // distance never exceeds the string capacity
  `LEV_ASSERT_NOW(a_dist_range, rsp_valid_o, int'(rsp_o.distance) <= MAX_LEN)

endmodule

bind levenshtein_edit_distance_top lev_checker #(.MAX_LEN(MAX_LEN)) u_lev_checker (.*);

// ===== test/levenshtein_edit_distance_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking edit distance bench: directed cases, then random pairs and requests.
// Uses lev_pkg types; needs only levenshtein_edit_distance_top and its package.
module levenshtein_edit_distance_top_tb;
  import lev_pkg::*;

  localparam int MaxLen  = MaxLenDefault;
  localparam int CalmTail = 100;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     req_valid_i = 1'b0;
  logic     req_stall_o;
  lev_req_t req_i       = '0;
  logic     rsp_valid_o;
  logic     rsp_stall_i = 1'b0;
  lev_rsp_t rsp_o;

  levenshtein_edit_distance_top #(.MAX_LEN(MaxLen)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the engine state
  logic [CharW-1:0] tgt_chars [MaxLen];
  int               col_cost  [MaxLen+1];
  int               tgt_len   = 0;
  int               src_len   = 0;
  logic             err_flag  = 1'b0;

  lev_req_t request_backlog [$];
  lev_rsp_t distance_due    [$];
  int       fail_count = 0;
  logic     calm = 1'b0;
  int       gap_left = 0;
  int       stall_left = 0;

  task automatic advance_edit_state(input lev_req_t rq);
    int diag, left, up, sub, v;
    lev_rsp_t rs;
    case (rq.opcode)
      OP_START: begin
        tgt_len  = 0;
        src_len  = 0;
        err_flag = 1'b0;
      end
      OP_TARGET: begin
        if (src_len != 0 || tgt_len >= MaxLen) begin
          err_flag = 1'b1;
        end else begin
          tgt_chars[tgt_len]  = rq.char_code;
          col_cost[tgt_len+1] = tgt_len + 1;
          tgt_len++;
        end
      end
      OP_SOURCE: begin
        if (src_len >= MaxLen) begin
          err_flag = 1'b1;
        end else begin
          // walk the column in place, keeping the old entry as the next diagonal
          diag = src_len;
          left = src_len + 1;
          for (int j = 0; j < tgt_len; j++) begin
            up   = col_cost[j+1];
            sub  = diag + ((tgt_chars[j] == rq.char_code) ? 0 : 1);
            v    = left + 1;
            if (up + 1 < v) v = up + 1;
            if (sub < v) v = sub;
            diag = up;
            col_cost[j+1] = v;
            left = v;
          end
          src_len++;
        end
      end
      default: begin
        rs.distance     = DistW'((tgt_len == 0) ? src_len : col_cost[tgt_len]);
        rs.length_error = err_flag;
        distance_due.insert(distance_due.size(), rs);
      end
    endcase
  endtask

  task automatic queue_request(input lev_op_e op, input logic [CharW-1:0] ch);
    lev_req_t rq;
    rq.opcode    = op;
    rq.char_code = ch;
    request_backlog.insert(request_backlog.size(), rq);
  endtask

  // One pair: start, targets, sources, finish; narrow alphabets make matches likely.
  task automatic queue_pair(input int nt, input int ns, input bit wide);
    logic [CharW-1:0] base;
    base = CharW'($urandom);
    queue_request(OP_START, CharW'($urandom));
    for (int k = 0; k < nt; k++)
      queue_request(OP_TARGET, wide ? CharW'($urandom) : (base ^ CharW'($urandom_range(0, 3))));
    for (int k = 0; k < ns; k++) begin
      if ($urandom_range(0, 29) == 0)
        queue_request(OP_TARGET, CharW'($urandom));
      queue_request(OP_SOURCE, wide ? CharW'($urandom) : (base ^ CharW'($urandom_range(0, 3))));
    end
    queue_request(OP_FINISH, CharW'($urandom));
    if ($urandom_range(0, 7) == 0)
      queue_request(OP_FINISH, CharW'($urandom));
  endtask

  // Driver: apply accepted requests to the shadow, then present the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      req_i       <= '0;
      calm        <= 1'b0;
      gap_left    = 0;
    end else begin
      calm <= (request_backlog.size() < CalmTail);
      if (req_valid_i && !req_stall_o)
        advance_edit_state(req_i);
      if (!req_valid_i || !req_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid_i <= 1'b0;
        end else if (request_backlog.size() >= CalmTail && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 3);
          req_valid_i <= 1'b0;
        end else if (request_backlog.size() > 0) begin
          req_i       <= request_backlog.pop_front();
          req_valid_i <= 1'b1;
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expected distance
  always @(posedge clk_i or negedge rst_ni) begin
    lev_rsp_t want;
    if (!rst_ni) begin
      rsp_stall_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (rsp_valid_o && !rsp_stall_i) begin
        if (distance_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: distance %0d length_error %0b",
                     rsp_o.distance, rsp_o.length_error);
        end else begin
          want = distance_due.pop_front();
          if (rsp_o.distance !== want.distance || rsp_o.length_error !== want.length_error) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected distance %0d length_error %0b, got %0d %0b",
                       want.distance, want.length_error, rsp_o.distance, rsp_o.length_error);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        rsp_stall_i <= 1'b1;
      end else begin
        rsp_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int kind;
    // before any start, then a mixed pair with extreme characters
    queue_request(OP_FINISH, 16'hFFFF);
    queue_request(OP_TARGET, 16'hFFFF);
    queue_request(OP_SOURCE, 16'h0000);
    queue_request(OP_FINISH, 16'h0000);
    queue_request(OP_START, 16'hFFFF);
    queue_request(OP_TARGET, 16'h0000);
    queue_request(OP_TARGET, 16'hFFFF);
    queue_request(OP_SOURCE, 16'hFFFF);
    queue_request(OP_FINISH, 16'h5555);
    // target after source, then a repeated finish
    queue_request(OP_TARGET, 16'hAAAA);
    queue_request(OP_FINISH, 16'h0000);
    queue_request(OP_FINISH, 16'hFFFF);
    // empty target
    queue_request(OP_START, 16'h0000);
    queue_request(OP_SOURCE, 16'h1234);
    queue_request(OP_SOURCE, 16'h8001);
    queue_request(OP_SOURCE, 16'h7FFE);
    queue_request(OP_FINISH, 16'h0000);
    // empty source
    queue_request(OP_START, 16'h0000);
    queue_request(OP_TARGET, 16'h00FF);
    queue_request(OP_TARGET, 16'hFF00);
    queue_request(OP_FINISH, 16'h0000);
    // both empty
    queue_request(OP_START, 16'h0000);
    queue_request(OP_FINISH, 16'h0000);

    // full strings and overflow on each side
    queue_pair(MaxLen + 2, 2, 1'b0);
    queue_pair(3, MaxLen + 2, 1'b0);
    queue_pair(MaxLen, MaxLen, 1'b0);
    while (request_backlog.size() < 1000) begin
      kind = $urandom_range(0, 39);
      if (kind == 0)
        queue_pair($urandom_range(MaxLen - 4, MaxLen + 2),
                   $urandom_range(MaxLen - 4, MaxLen + 2), $urandom_range(0, 1));
      else if (kind < 4)
        queue_request(lev_op_e'($urandom_range(0, 3)), CharW'($urandom));
      else
        queue_pair($urandom_range(0, 8), $urandom_range(0, 8), (kind % 4) == 0);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_backlog.size() != 0 || req_valid_i)
      @(posedge clk_i);
    while (distance_due.size() != 0)
      @(posedge clk_i);
    // let a trailing source char finish its column walk
    repeat (4 * MaxLen) @(posedge clk_i);
    if (distance_due.size() != 0)
      fail_count++;
    if (fail_count == 0) begin
      $display("PASS levenshtein_edit_distance_top");
    end else begin
      $display("FAIL levenshtein_edit_distance_top");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL levenshtein_edit_distance_top");
    $finish;
  end

endmodule
